// ----- hw/rtl/sha1he_pkg.sv -----
// Shared types, constants and helper functions of the SHA-1 hash engine.
package sha1he_pkg;

	typedef logic [31:0] word_t;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam logic [7:0] MarkByte    = 8'h80;
	localparam logic [5:0] PreLenFill  = 6'd55;
	localparam logic [5:0] LastFill    = 6'd63;
	localparam logic [6:0] LastRound   = 7'd79;
	localparam logic [2:0] LastWordIdx = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MARK,
		S_ZERO,
		S_LEN,
		S_COMP,
		S_ADD,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		BSEL_IN,
		BSEL_MARK,
		BSEL_ZERO,
		BSEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      put_byte;
		byte_sel_t byte_sel;
		logic      count_bits;
		logic      round_en;
		logic      add_chain;
		logic      emit_adv;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       round_last;
		logic [2:0] word_idx;
		word_t      digest;
	} status_t;

	// Initial chaining value of each digest word.
	function automatic word_t init_word(input logic [2:0] idx);
		word_t w;
		case (idx)
			3'd0: w = 32'h67452301;
			3'd1: w = 32'hEFCDAB89;
			3'd2: w = 32'h98BADCFE;
			3'd3: w = 32'h10325476;
			3'd4: w = 32'hC3D2E1F0;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ----- hw/rtl/sha1he_ctrl.sv -----
// Sequencing state machine of the SHA-1 hash engine: intake, padding, rounds and output.
module sha1he_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_has_byte,
	input  logic                in_end,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sha1he_pkg::status_t st,
	output sha1he_pkg::cmd_t    cmd
);

	sha1he_pkg::state_t state_q, state_d;
	sha1he_pkg::state_t resume_q, resume_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha1he_pkg::S_IDLE;
			resume_q <= sha1he_pkg::S_IDLE;
		end else begin
			state_q  <= state_d;
			resume_q <= resume_d;
		end
	end

	// Next state; resume_q remembers where to go once a block is compressed.
	always_comb begin
		state_d  = state_q;
		resume_d = resume_q;
		case (state_q)
			sha1he_pkg::S_IDLE: begin
				if (in_valid) begin
					if (in_has_byte && st.fill == sha1he_pkg::LastFill) begin
						state_d  = sha1he_pkg::S_COMP;
						resume_d = in_end ? sha1he_pkg::S_MARK : sha1he_pkg::S_IDLE;
					end else if (in_end) begin
						state_d = sha1he_pkg::S_MARK;
					end
				end
			end
			sha1he_pkg::S_MARK, sha1he_pkg::S_ZERO: begin
				if (st.fill == sha1he_pkg::PreLenFill) begin
					state_d = sha1he_pkg::S_LEN;
				end else if (st.fill == sha1he_pkg::LastFill) begin
					state_d  = sha1he_pkg::S_COMP;
					resume_d = sha1he_pkg::S_ZERO;
				end else begin
					state_d = sha1he_pkg::S_ZERO;
				end
			end
			sha1he_pkg::S_LEN: begin
				if (st.fill == sha1he_pkg::LastFill) begin
					state_d  = sha1he_pkg::S_COMP;
					resume_d = sha1he_pkg::S_EMIT;
				end
			end
			sha1he_pkg::S_COMP: begin
				if (st.round_last) begin
					state_d = sha1he_pkg::S_ADD;
				end
			end
			sha1he_pkg::S_ADD: begin
				state_d = resume_q;
			end
			sha1he_pkg::S_EMIT: begin
				if (out_ready && st.word_idx == sha1he_pkg::LastWordIdx) begin
					state_d = sha1he_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sha1he_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd            = '0;
		cmd.byte_sel   = sha1he_pkg::BSEL_IN;
		case (state_q)
			sha1he_pkg::S_IDLE: begin
				in_ready       = 1'b1;
				cmd.put_byte   = in_valid && in_has_byte;
				cmd.count_bits = in_valid && in_has_byte;
			end
			sha1he_pkg::S_MARK: begin
				cmd.put_byte = 1'b1;
				cmd.byte_sel = sha1he_pkg::BSEL_MARK;
			end
			sha1he_pkg::S_ZERO: begin
				cmd.put_byte = 1'b1;
				cmd.byte_sel = sha1he_pkg::BSEL_ZERO;
			end
			sha1he_pkg::S_LEN: begin
				cmd.put_byte = 1'b1;
				cmd.byte_sel = sha1he_pkg::BSEL_LEN;
			end
			sha1he_pkg::S_COMP: begin
				cmd.round_en = 1'b1;
			end
			sha1he_pkg::S_ADD: begin
				cmd.add_chain = 1'b1;
			end
			sha1he_pkg::S_EMIT: begin
				out_valid    = 1'b1;
				cmd.emit_adv = out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/sha1he_datapath.sv -----
// Datapath of the SHA-1 hash engine: block and schedule shift register, round unit, chain words.
module sha1he_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sha1he_pkg::cmd_t    cmd,
	input  logic [7:0]          in_byte,
	output sha1he_pkg::status_t st
);

	// Bytes shift in at the low end of w_q[15]; after 64 bytes w_q[0] holds the first word.
	// During the rounds the same registers roll as the message schedule, w_q[0] being current.
	sha1he_pkg::word_t w_q [16];
	sha1he_pkg::word_t chain_q [5];
	sha1he_pkg::word_t a_q, b_q, c_q, d_q, e_q;
	logic [5:0]        fill_q;
	logic [63:0]       bit_count_q;
	logic [6:0]        round_q;
	logic [2:0]        word_idx_q;

	logic [7:0]        byte_d;
	sha1he_pkg::word_t f_val, k_val, w_new, t_sum;

	always_comb begin
		case (cmd.byte_sel)
			sha1he_pkg::BSEL_IN:   byte_d = in_byte;
			sha1he_pkg::BSEL_MARK: byte_d = sha1he_pkg::MarkByte;
			sha1he_pkg::BSEL_ZERO: byte_d = 8'h00;
			sha1he_pkg::BSEL_LEN:  byte_d = bit_count_q[{~fill_q[2:0], 3'b000} +: 8];
			default:               byte_d = 8'h00;
		endcase
	end

	always_comb begin
		case (round_q) inside
			[7'd0:7'd19]: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				k_val = sha1he_pkg::K0;
			end
			[7'd20:7'd39]: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = sha1he_pkg::K1;
			end
			[7'd40:7'd59]: begin
				f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k_val = sha1he_pkg::K2;
			end
			default: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = sha1he_pkg::K3;
			end
		endcase
	end

	assign w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign t_sum = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];

	always_ff @(posedge clk) begin
		if (cmd.put_byte) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], byte_d};
			a_q     <= chain_q[0];
			b_q     <= chain_q[1];
			c_q     <= chain_q[2];
			d_q     <= chain_q[3];
			e_q     <= chain_q[4];
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= {w_new[30:0], w_new[31]};
			a_q     <= t_sum;
			b_q     <= a_q;
			c_q     <= {b_q[1:0], b_q[31:2]};
			d_q     <= c_q;
			e_q     <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= sha1he_pkg::init_word(3'(i));
			end
			fill_q      <= '0;
			bit_count_q <= '0;
			round_q     <= '0;
			word_idx_q  <= '0;
		end else begin
			if (cmd.put_byte) begin
				fill_q  <= fill_q + 6'd1;
				round_q <= '0;
			end else if (cmd.round_en) begin
				round_q <= round_q + 7'd1;
			end
			if (cmd.count_bits) begin
				bit_count_q <= bit_count_q + 64'd8;
			end
			if (cmd.add_chain) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.emit_adv) begin
				if (word_idx_q == sha1he_pkg::LastWordIdx) begin
					// Digest delivered: back to the initial values for the next message.
					word_idx_q  <= '0;
					bit_count_q <= '0;
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= sha1he_pkg::init_word(3'(i));
					end
				end else begin
					word_idx_q <= word_idx_q + 3'd1;
				end
			end
		end
	end

	always_comb begin
		st.fill       = fill_q;
		st.round_last = (round_q == sha1he_pkg::LastRound);
		st.word_idx   = word_idx_q;
		case (word_idx_q)
			3'd0:    st.digest = chain_q[0];
			3'd1:    st.digest = chain_q[1];
			3'd2:    st.digest = chain_q[2];
			3'd3:    st.digest = chain_q[3];
			3'd4:    st.digest = chain_q[4];
			default: st.digest = chain_q[0];
		endcase
	end

endmodule

// ----- hw/rtl/sha1_hash_engine.sv -----
// SHA-1 hash engine top level: byte stream in, five digest words out.
//
// Usage. Message bytes arrive on the slave stream, one per beat: the byte in s_axis_tdata,
// s_axis_tuser high when the beat really carries a byte, and s_axis_tlast on the final beat
// of a message. A beat with tuser low and tlast high closes the message without a byte, and
// on its own it hashes the empty message. A beat with neither flag is taken and ignored.
// Timing. A byte is taken on every beat while s_axis_tready is high. The 64th byte of a block
// starts a compression (80 rounds, one per cycle, then the chain update) during which
// s_axis_tready is low; the round unit and the shared byte/schedule shift register set its
// length. After the closing beat the engine pads one byte a cycle outside the compressions
// (the marker, zeros, then the 64-bit bit length), compressing once or twice before the
// first digest beat.
// Output. The five digest words then leave on the master stream, h0 first, with their index
// in tdata and tlast on the fifth. A stalled receiver simply holds the engine: the current
// word waits, and no new input is taken until the last word is delivered, after which the
// chain returns to the initial values. Reset clears the controller, the length and the fill
// count and loads the initial chain; the engine is ready as soon as reset is released.
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] has_byte
	input  logic        s_axis_tlast,  // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_axis_tlast   // last_word
);

	sha1he_pkg::cmd_t    cmd;
	sha1he_pkg::status_t st;

	sha1he_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_has_byte (s_axis_tuser),
		.in_end      (s_axis_tlast),
		.in_ready    (s_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.st          (st),
		.cmd         (cmd)
	);

	sha1he_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_byte (s_axis_tdata),
		.st      (st)
	);

	// The digest word comes straight from the chain registers and its index from the word counter.
	assign m_axis_tdata = {5'b00000, st.word_idx, st.digest};
	assign m_axis_tlast = (st.word_idx == sha1he_pkg::LastWordIdx);

`ifndef NO_ASSERTIONS
	// While the digest is being delivered no input beat may be taken.
	a_no_intake_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted while digest words are pending");

	// The chain update follows directly on the last round.
	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_chain |-> $past(cmd.round_en && st.round_last))
		else $error("chain update without a completed round sequence");

	// The fill count moves only when a byte enters the block.
	a_fill_moves_on_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.put_byte |=> st.fill == $past(st.fill))
		else $error("fill count changed without a byte");

	// A digest is only delivered once the padded message has filled whole blocks.
	a_emit_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> st.fill == 6'd0)
		else $error("digest delivered with a partly filled block");
`endif

endmodule
